@@ src/bldc_six_step_commutator_core_macros.svh @@
// assertion macros for the six-step commutator core
// no dependencies; included by the rtl files that carry assertions
`ifndef BLDC_SIX_STEP_COMMUTATOR_CORE_MACROS_SVH
`define BLDC_SIX_STEP_COMMUTATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/bsc_pkg.sv @@
// types, constants and commutation table for the six-step commutator core
// no dependencies
`default_nettype none

package bsc_pkg;

    localparam int ANGLE_BITS  = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int SECTOR_DEG  = 60;
    localparam int TURN_DEG    = 360;
    localparam int CMD_STOP    = 127;
    localparam int FREE_LOW    = 255;

    localparam logic [4:0]        POLE_PAIRS_RST = 5'd7;
    localparam logic signed [9:0] FWD_OFFSET_RST = -10'sd60;
    localparam logic signed [9:0] REV_OFFSET_RST = -10'sd160;
    localparam logic [6:0]        MAX_SPEED_RST  = 7'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_PAIRS = 2'd0,
        REG_FWD_OFFSET = 2'd1,
        REG_REV_OFFSET = 2'd2,
        REG_MAX_SPEED  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t a;
        mode_t b;
        mode_t c;
    } step_row_t;

    typedef struct packed {
        logic                  cmd_valid;
        logic [7:0]            cmd_byte;
        logic [ANGLE_BITS-1:0] angle_raw;
        logic                  angle_error;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        phase_a_high;
        logic [7:0]        phase_a_low;
        logic [7:0]        phase_b_high;
        logic [7:0]        phase_b_low;
        logic [7:0]        phase_c_high;
        logic [7:0]        phase_c_low;
        logic [2:0]        sector;
        logic signed [7:0] speed_now;
    } out_item_t;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
    } gate_pair_t;

    function automatic step_row_t step_row(input logic [2:0] sector);
        step_row_t row;
        case (sector)
            3'd0:    row = '{a: MODE_HIGH, b: MODE_LOW,  c: MODE_FREE};
            3'd1:    row = '{a: MODE_HIGH, b: MODE_FREE, c: MODE_LOW };
            3'd2:    row = '{a: MODE_FREE, b: MODE_HIGH, c: MODE_LOW };
            3'd3:    row = '{a: MODE_LOW,  b: MODE_HIGH, c: MODE_FREE};
            3'd4:    row = '{a: MODE_LOW,  b: MODE_FREE, c: MODE_HIGH};
            3'd5:    row = '{a: MODE_FREE, b: MODE_LOW,  c: MODE_HIGH};
            default: row = '{a: MODE_FREE, b: MODE_FREE, c: MODE_FREE};
        endcase
        return row;
    endfunction

    function automatic gate_pair_t drive_phase(input mode_t mode, input logic [7:0] duty);
        gate_pair_t g;
        case (mode)
            MODE_HIGH: g = '{hi: duty, lo: duty};
            MODE_LOW:  g = '{hi: 8'd0, lo: 8'd0};
            default:   g = '{hi: 8'd0, lo: 8'(FREE_LOW)};
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ src/bldc_six_step_commutator_core.sv @@
// sensored six-step commutator: speed command, electrical sector and gate duties
// depends on bsc_pkg and bldc_six_step_commutator_core_macros.svh
//
// One item per clock is taken unless the result register stalls, and one result item
// is given for each via an input register, the angle, sector and gate logic and a result
// register. A stalled result register holds the input register, which still takes one
// more item. Speed and held sector are updated as an item moves into the result register,
// so the next item sees them at once. Configuration writes take effect on the next clock;
// the user must make them only while the block is idle, and the block does not enforce it.
`default_nettype none

`include "bldc_six_step_commutator_core_macros.svh"

module bldc_six_step_commutator_core
    import bsc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item
);

    logic [4:0]        pole_pairs_reg;
    logic signed [9:0] fwd_offset_reg;
    logic signed [9:0] rev_offset_reg;
    logic [6:0]        max_speed_reg;
    logic signed [7:0] speed_reg;
    logic [2:0]        held_sector_reg;
    logic              in_valid_reg;
    in_item_t          in_item_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              advance;
    logic signed [9:0] cmd_diff;
    logic signed [9:0] cmd_scaled;
    logic signed [9:0] lim;
    logic signed [7:0] speed_next;
    logic signed [9:0] offset;
    logic [ANGLE_BITS+4:0] elec_prod;
    logic [ANGLE_BITS+8:0] elec_scaled;
    logic [8:0]        deg_int;
    logic signed [11:0] deg_diff;
    logic [8:0]        deg_wrap;
    logic [2:0]        angle_sector;
    logic [2:0]        held_sector_next;
    logic [7:0]        duty;
    step_row_t         row;
    gate_pair_t        gate_a;
    gate_pair_t        gate_b;
    gate_pair_t        gate_c;
    out_item_t         out_item_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pole_pairs_reg <= POLE_PAIRS_RST;
            fwd_offset_reg <= FWD_OFFSET_RST;
            rev_offset_reg <= REV_OFFSET_RST;
            max_speed_reg  <= MAX_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLE_PAIRS: pole_pairs_reg <= cfg_wdata[4:0];
                REG_FWD_OFFSET: fwd_offset_reg <= $signed(cfg_wdata);
                REG_REV_OFFSET: rev_offset_reg <= $signed(cfg_wdata);
                REG_MAX_SPEED:  max_speed_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // speed command, doubled and clamped to the limit; held when no command is valid
    always_comb begin
        cmd_diff   = $signed({2'b00, in_item_reg.cmd_byte}) - 10'(CMD_STOP);
        cmd_scaled = {cmd_diff[8:0], 1'b0};
        lim        = $signed({3'b000, max_speed_reg});
        if (!in_item_reg.cmd_valid) begin
            speed_next = speed_reg;
        end else if (cmd_scaled > lim) begin
            speed_next = lim[7:0];
        end else if (cmd_scaled < -lim) begin
            speed_next = 8'(-lim);
        end else begin
            speed_next = cmd_scaled[7:0];
        end
    end

    // electrical angle and sector, held on an angle error: only the fraction of a turn of pole_pairs * angle matters
    always_comb begin
        offset      = (speed_next > 8'sd0) ? fwd_offset_reg : rev_offset_reg;
        elec_prod   = pole_pairs_reg * in_item_reg.angle_raw;
        elec_scaled = {9'd0, elec_prod[ANGLE_BITS-1:0]} * (ANGLE_BITS+9)'(TURN_DEG);
        deg_int     = elec_scaled[ANGLE_BITS+8:ANGLE_BITS];
        deg_diff    = $signed({3'b000, deg_int}) - {{2{offset[9]}}, offset};
        if (deg_diff < -12'sd360) begin
            deg_wrap = 9'(deg_diff + 12'(2 * TURN_DEG));
        end else if (deg_diff < 12'sd0) begin
            deg_wrap = 9'(deg_diff + 12'(TURN_DEG));
        end else if (deg_diff >= 12'(2 * TURN_DEG)) begin
            deg_wrap = 9'(deg_diff - 12'(2 * TURN_DEG));
        end else if (deg_diff >= 12'(TURN_DEG)) begin
            deg_wrap = 9'(deg_diff - 12'(TURN_DEG));
        end else begin
            deg_wrap = deg_diff[8:0];
        end
        if (deg_wrap < 9'(SECTOR_DEG)) begin
            angle_sector = 3'd0;
        end else if (deg_wrap < 9'(2 * SECTOR_DEG)) begin
            angle_sector = 3'd1;
        end else if (deg_wrap < 9'(3 * SECTOR_DEG)) begin
            angle_sector = 3'd2;
        end else if (deg_wrap < 9'(4 * SECTOR_DEG)) begin
            angle_sector = 3'd3;
        end else if (deg_wrap < 9'(5 * SECTOR_DEG)) begin
            angle_sector = 3'd4;
        end else begin
            angle_sector = 3'd5;
        end
        held_sector_next = in_item_reg.angle_error ? held_sector_reg : angle_sector;
    end

    // gate pattern
    always_comb begin
        duty   = (speed_next < 8'sd0) ? 8'(-speed_next) : speed_next;
        row    = step_row(held_sector_next);
        gate_a = drive_phase(row.a, duty);
        gate_b = drive_phase(row.b, duty);
        gate_c = drive_phase(row.c, duty);
        out_item_next.phase_a_high = gate_a.hi;
        out_item_next.phase_a_low  = gate_a.lo;
        out_item_next.phase_b_high = gate_b.hi;
        out_item_next.phase_b_low  = gate_b.lo;
        out_item_next.phase_c_high = gate_c.hi;
        out_item_next.phase_c_low  = gate_c.lo;
        out_item_next.sector       = held_sector_next;
        out_item_next.speed_now    = speed_next;
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            speed_reg       <= 8'sd0;
            held_sector_reg <= 3'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                speed_reg       <= speed_next;
                held_sector_reg <= held_sector_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    `BSC_ASSERT_NOW(a_held_sector_range, aclk, aresetn, 1'b1, held_sector_reg <= 3'd5)
    `BSC_ASSERT_NOW(a_one_free_phase, aclk, aresetn, m_valid,
        $countones({m_item.phase_a_low == 8'hFF, m_item.phase_b_low == 8'hFF,
                    m_item.phase_c_low == 8'hFF}) == 1)
    `BSC_ASSERT_NEXT(a_error_holds_sector, aclk, aresetn,
        advance && in_item_reg.angle_error, $stable(held_sector_reg))
    `BSC_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready)

endmodule

`default_nettype wire
